>>> design/stg_pkg.sv
// shared types and constants for the square tone generator
// no dependencies
package stg_pkg;

  localparam int TONE_W   = 16;
  localparam int LEVEL_W  = 15;
  localparam int PHASE_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_LEVEL   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOUD_LEVEL     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_INCREMENT = 2'd2;

  localparam logic [LEVEL_W-1:0] NORMAL_LEVEL_RST   = 15'd6000;
  localparam logic [LEVEL_W-1:0] LOUD_LEVEL_RST     = 15'd14000;
  localparam logic [LEVEL_W-1:0] RAMP_INCREMENT_RST = 15'd109;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic               tone_zero;
    logic               loud;
  } tick_t;

endpackage

>>> design/stg_front.sv
// front end: accepts ticks and works out the phase step, hz * 65536 / rate
// uses stg_pkg; three pipeline stages with reciprocal multiply and correction
module stg_front #(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [stg_pkg::TONE_W-1:0] tone_hz,
  input  logic                      loud,
  output logic                      out_valid,
  input  logic                      out_ready,
  output stg_pkg::tick_t            out_tick
);
  import stg_pkg::*;

  localparam longint unsigned RECIP = 64'h1_0000_0000 / SAMPLE_RATE;
  localparam int RATE_W  = $clog2(SAMPLE_RATE + 1);
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int REM_W   = RATE_W + 1;
  localparam int STEP_W  = RECIP_W + 1;
  localparam logic [RATE_W-1:0]  RATE_C  = RATE_W'(SAMPLE_RATE);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic                      v1, v2, v3;
  logic                      adv1, adv2, adv3;
  logic [TONE_W-1:0]         hz1, hz2;
  logic                      loud1, loud2, loud3;
  logic [RECIP_W-1:0]        qe1, qe2;
  logic [REM_W-1:0]          prod2;
  logic [TONE_W+RECIP_W-1:0] prod1_full;
  logic [RECIP_W+RATE_W-1:0] prod2_full;
  logic [31:0]               num2;
  logic [REM_W-1:0]          rem2;
  logic [STEP_W-1:0]         step_full;
  logic [PHASE_W-1:0]        step3;
  logic                      zero3;

  assign adv3 = !v3 || out_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  assign prod1_full = tone_hz * RECIP_C;
  assign prod2_full = qe1 * RATE_C;
  assign num2       = {hz2, 16'b0};
  assign rem2       = num2[REM_W-1:0] - prod2;
  assign step_full  = {1'b0, qe2} + STEP_W'(rem2 >= REM_W'(RATE_C));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      hz1   <= tone_hz;
      loud1 <= loud;
      qe1   <= prod1_full[TONE_W +: RECIP_W];
    end
    if (adv2 && v1) begin
      hz2   <= hz1;
      loud2 <= loud1;
      qe2   <= qe1;
      prod2 <= prod2_full[REM_W-1:0];
    end
    if (adv3 && v2) begin
      step3 <= PHASE_W'(step_full);
      zero3 <= (hz2 == '0);
      loud3 <= loud2;
    end
  end

  assign out_valid          = v3;
  assign out_tick.step      = step3;
  assign out_tick.tone_zero = zero3;
  assign out_tick.loud      = loud3;

endmodule

>>> design/stg_queue.sv
// short queue between front and back so each side stalls on its own
// uses stg_pkg
module stg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stg_pkg::tick_t in_tick,
  output logic           out_valid,
  input  logic           out_ready,
  output stg_pkg::tick_t out_tick
);
  import stg_pkg::*;

  tick_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   push, pop;

  assign in_ready  = (count != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_tick  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_tick;
  end

endmodule

>>> design/stg_back.sv
// back end: level ramp, phase accumulator, sample output register
// uses stg_pkg; holds the configuration registers
module stg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [stg_pkg::LEVEL_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  stg_pkg::tick_t                in_tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stg_pkg::SAMPLE_W-1:0]   sample
);
  import stg_pkg::*;

  logic [LEVEL_W-1:0]  normal_level, loud_level, ramp_increment;
  logic [LEVEL_W-1:0]  level_now, level_next, target;
  logic [PHASE_W-1:0]  phase_acc, phase_next;
  logic [LEVEL_W:0]    level_sum;
  logic [LEVEL_W-1:0]  level_diff;
  logic [SAMPLE_W-1:0] mag;
  logic                take;

  assign take     = in_valid && (!out_valid || out_ready);
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (in_tick.tone_zero) begin
      target = '0;
    end else if (in_tick.loud) begin
      target = loud_level;
    end else begin
      target = normal_level;
    end
    level_sum  = {1'b0, level_now} + {1'b0, ramp_increment};
    level_diff = level_now - target;
    if (level_now < target) begin
      level_next = (level_sum > {1'b0, target}) ? target : level_sum[LEVEL_W-1:0];
    end else if (level_now > target) begin
      level_next = (level_diff <= ramp_increment) ? target : level_now - ramp_increment;
    end else begin
      level_next = level_now;
    end
    phase_next = phase_acc + in_tick.step;
    mag        = {1'b0, level_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_level   <= NORMAL_LEVEL_RST;
      loud_level     <= LOUD_LEVEL_RST;
      ramp_increment <= RAMP_INCREMENT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NORMAL_LEVEL:   normal_level   <= cfg_wdata;
        REG_LOUD_LEVEL:     loud_level     <= cfg_wdata;
        REG_RAMP_INCREMENT: ramp_increment <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now <= '0;
      phase_acc <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      level_now <= level_next;
      phase_acc <= phase_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) sample <= phase_next[PHASE_W-1] ? mag : -mag;
  end

endmodule

>>> design/square_tone_generator_with_ramp.sv
// top level of the square tone generator with amplitude ramp
// uses stg_pkg, stg_front, stg_queue, stg_back
//
// each input item on s_axis is one audio sample tick carrying the tone
// frequency in hz and a loud flag; each tick yields exactly one signed
// sample on m_axis, in order. a tone of 0 hz holds the phase and lets the
// level ramp down to silence.
// the front computes the phase step with a reciprocal multiply and a one
// step correction over three stages, a four entry queue follows, and the
// back updates level and phase and registers the sample.
// a tick passes the three front stages, the queue and the back end's sample
// register before its sample is valid. throughput: one tick per cycle while
// m_axis_tready stays high; the back end updates phase and level per tick.
// reset (rst, synchronous) clears phase and level, loads the default
// levels and empties the pipeline. when m_axis_tready is low the output
// holds, the queue and front stages fill, then s_axis_tready drops.
// configuration must be written through cfg_we/cfg_addr/cfg_wdata while idle; the block does not enforce this.
module square_tone_generator_with_ramp #(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [stg_pkg::LEVEL_W-1:0]    cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // tone_hz
  input  logic                          s_axis_tuser,   // loud
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata    // sample
);
  import stg_pkg::*;

  logic  front_valid, front_ready;
  tick_t front_tick;
  logic  queue_valid, queue_ready;
  tick_t queue_tick;

  stg_front #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .tone_hz   (s_axis_tdata),
    .loud      (s_axis_tuser),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_tick  (front_tick)
  );

  stg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_tick   (front_tick),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_tick  (queue_tick)
  );

  stg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (queue_valid),
    .in_ready  (queue_ready),
    .in_tick   (queue_tick),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sample    (m_axis_tdata)
  );

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for square_tone_generator_with_ramp
// depends on stg_pkg and the design top; tracks phase and ramped level per tick
// and compares every sample against a local prediction, under random idling
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stg_pkg::*;

  localparam int SAMPLE_RATE = 44100;
  localparam logic [31:0] RATE_DIV = 32'd44100;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7fff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_NORMAL_LEVEL;
  logic [LEVEL_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // tone_hz
  logic s_axis_tuser = 1'b0;       // loud
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // sample

  // predicted block state
  logic [PHASE_W-1:0] phase_now;
  logic [LEVEL_W-1:0] level_now;
  logic [LEVEL_W-1:0] normal_lvl;
  logic [LEVEL_W-1:0] loud_lvl;
  logic [LEVEL_W-1:0] ramp_inc;

  logic [SAMPLE_W-1:0] sample_q[$];
  logic [SAMPLE_W-1:0] want_sample;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_cnt = 0;

  square_tone_generator_with_ramp #(.SAMPLE_RATE(SAMPLE_RATE)) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL square_tone_generator_with_ramp");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] next_sample(logic [15:0] hz, logic loud);
    logic [LEVEL_W-1:0] target;
    logic [15:0] sum;
    logic [31:0] step;
    logic [SAMPLE_W-1:0] mag;
    target = (hz == 0) ? '0 : (loud ? loud_lvl : normal_lvl);
    if (level_now < target) begin
      sum = {1'b0, level_now} + {1'b0, ramp_inc};
      level_now = (sum > {1'b0, target}) ? target : sum[LEVEL_W-1:0];
    end else if (level_now > target) begin
      level_now = ((level_now - target) <= ramp_inc) ? target : level_now - ramp_inc;
    end
    step = {hz, 16'h0000} / RATE_DIV;
    if (step != 0) phase_now = phase_now + step[PHASE_W-1:0];
    mag = {1'b0, level_now};
    return phase_now[PHASE_W-1] ? mag : 16'h0000 - mag;
  endfunction

  // receiver side: random stalls plus an occasional long hold
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        $error("sample: no request pending, actual %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        want_sample = sample_q.pop_front();
        if (m_axis_tdata !== want_sample) begin
          $error("sample: expected %0d, actual %0d", $signed(want_sample),
                 $signed(m_axis_tdata));
          fail_count++;
        end
      end
    end
  end

  task automatic send_tick(input logic [15:0] hz, input logic loud);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= hz;
    s_axis_tuser <= loud;
    do @(posedge clk); while (!s_axis_tready);
    sample_q.push_back(next_sample(hz, loud));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [LEVEL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_NORMAL_LEVEL:   normal_lvl = val;
      REG_LOUD_LEVEL:     loud_lvl = val;
      REG_RAMP_INCREMENT: ramp_inc = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_run(input logic [15:0] hz, input logic loud, input int n);
    repeat (n) send_tick(hz, loud);
  endtask

  function automatic logic [15:0] pick_tone();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'd0;
    else if (sel == 1) return 16'($urandom_range(1, 3));
    else if (sel <= 4) return 16'($urandom_range(100, 2000));
    else if (sel == 5) return 16'($urandom_range(20000, 24000));
    else if (sel == 6) return 16'($urandom_range(43000, 45000));
    else return 16'($urandom);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    else if (sel == 1) return LEVEL_MAX;
    else return LEVEL_W'($urandom);
  endfunction

  task automatic test_default_tones();
    send_run(16'd0, 1'b0, 2);
    send_tick(16'd1, 1'b0);
    send_tick(16'hffff, 1'b1);
    send_run(16'd22050, 1'b0, 3);
    send_run(16'd44100, 1'b1, 2);
    send_run(16'd440, 1'b1, 4);
    send_run(16'd0, 1'b1, 3);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h7fff, 1'b1);
    send_run(16'd1000, 1'b0, 3);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_NORMAL_LEVEL, LEVEL_MAX);
    write_reg(REG_LOUD_LEVEL, '0);
    write_reg(REG_RAMP_INCREMENT, LEVEL_MAX);
    send_run(16'd700, 1'b0, 3);
    send_run(16'd700, 1'b1, 2);
    send_run(16'd700, 1'b0, 2);
    wait_idle();
    // frozen ramp keeps the level wherever it was
    write_reg(REG_RAMP_INCREMENT, '0);
    send_run(16'd700, 1'b1, 2);
    send_run(16'd0, 1'b0, 2);
    wait_idle();
    write_reg(REG_UNUSED, 15'h1234);
    write_reg(REG_RAMP_INCREMENT, 15'd1);
    write_reg(REG_LOUD_LEVEL, LEVEL_MAX);
    send_run(16'd700, 1'b1, 3);
    wait_idle();
    write_reg(REG_NORMAL_LEVEL, '0);
    write_reg(REG_RAMP_INCREMENT, LEVEL_MAX);
    send_run(16'd3000, 1'b0, 3);
    send_run(16'd3000, 1'b1, 2);
    wait_idle();
    write_reg(REG_NORMAL_LEVEL, NORMAL_LEVEL_RST);
    write_reg(REG_LOUD_LEVEL, LOUD_LEVEL_RST);
    write_reg(REG_RAMP_INCREMENT, RAMP_INCREMENT_RST);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 60;
    send_run(16'd2500, 1'b1, 30);
    wait_idle();
    send_run(16'd0, 1'b0, 5);
    hold_len = 40;
    send_run(16'd12000, 1'b0, 10);
    wait_idle();
  endtask

  task automatic test_random_tones(input int send_pct, input int recv_pct, input int n);
    int sent;
    int run;
    logic [15:0] hz;
    logic loud;
    sent = 0;
    write_reg(REG_NORMAL_LEVEL, pick_level());
    write_reg(REG_LOUD_LEVEL, pick_level());
    write_reg(REG_RAMP_INCREMENT, ($urandom_range(1) == 0) ?
              LEVEL_W'($urandom_range(1, 400)) : LEVEL_W'($urandom_range(1, 32767)));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < n) begin
      hz = pick_tone();
      loud = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) begin
        // scattered single ticks
        send_tick(16'($urandom), 1'($urandom));
        sent++;
      end else begin
        run = $urandom_range(1, 30);
        send_run(hz, loud, run);
        sent += run;
      end
    end
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    phase_now = '0;
    level_now = '0;
    normal_lvl = NORMAL_LEVEL_RST;
    loud_lvl = LOUD_LEVEL_RST;
    ramp_inc = RAMP_INCREMENT_RST;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_tones();
    test_register_extremes();
    test_backpressure();
    test_random_tones(0, 0, 140);
    test_random_tones(88, 0, 140);
    test_random_tones(0, 88, 140);
    test_random_tones(18, 18, 140);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && sample_q.size() == 0) begin
      $display("PASS square_tone_generator_with_ramp");
    end else begin
      $display("FAIL square_tone_generator_with_ramp");
    end
    $finish;
  end

endmodule

>>> files.f
design/stg_pkg.sv
design/stg_front.sv
design/stg_queue.sv
design/stg_back.sv
design/square_tone_generator_with_ramp.sv
tb/sv/tb_top.sv
